// ===== src/assert_macros.svh =====
// Assertion macros shared by the routing block.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition that must hold at every clock edge outside reset.
`define SRBD_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("%m: check failed");

// Antecedent implies consequent in the same cycle.
`define SRBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Antecedent implies consequent in the next cycle.
`define SRBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: check failed");

`else

`define SRBD_ASSERT(lbl, clk, rst_n, cond)
`define SRBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SRBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/srbd_pkg.sv =====
`timescale 1ns / 1ps
// Types and constants of the send/return routing block.
// No dependencies.
package srbd_pkg;

    localparam int MAX_SENDS        = 8;
    localparam int DELAY_FIELD_BITS = 5;
    localparam int ROUTE_BITS       = 64;
    localparam int DELAY_REG_BITS   = 40;
    localparam int CFG_BITS         = 64;

    localparam logic [DELAY_FIELD_BITS-1:0] MIN_DELAY    = 5'd2;
    // Delay of two frames in every send
    localparam logic [DELAY_REG_BITS-1:0]   BYPASS_RESET = 40'd70936234050;

    typedef enum logic [1:0] {
        CFG_ROUTE_MASK       = 2'd0,
        CFG_BYPASS_DELAYS    = 2'd1,
        CFG_RETURN_CONNECTED = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic                 run;
        logic [MAX_SENDS-1:0] connected;
        logic [MAX_SENDS-1:0] routed;
    } t_stage_ctrl;

endpackage

// ===== src/srbd_history_mem.sv =====
`timescale 1ns / 1ps
// History ring of one send stage: one write port, one registered read port.
// No dependencies.
module srbd_history_mem #(
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold the last read while no new request is taken
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/srbd_send_chain.sv =====
`timescale 1ns / 1ps
// Walk of one sample through the send stages, given returns and history reads.
// Depends on srbd_pkg.
module srbd_send_chain #(
    parameter int SEND_COUNT  = 8,
    parameter int SAMPLE_BITS = 24
) (
    input  srbd_pkg::t_stage_ctrl          i_ctrl,
    input  logic signed [SAMPLE_BITS-1:0]  i_sample,
    input  logic signed [SAMPLE_BITS-1:0]  i_ret      [srbd_pkg::MAX_SENDS],
    input  logic signed [SAMPLE_BITS-1:0]  i_hist     [srbd_pkg::MAX_SENDS],
    output logic signed [SAMPLE_BITS-1:0]  o_value,
    output logic [srbd_pkg::MAX_SENDS-1:0] o_written,
    output logic signed [SAMPLE_BITS-1:0]  o_send     [srbd_pkg::MAX_SENDS],
    output logic signed [SAMPLE_BITS-1:0]  o_stage_in [srbd_pkg::MAX_SENDS]
);

    always_comb begin
        logic signed [SAMPLE_BITS-1:0] v;
        v         = i_sample;
        o_written = '0;
        for (int s = 0; s < srbd_pkg::MAX_SENDS; s++) begin
            o_send[s]     = '0;
            o_stage_in[s] = '0;
        end
        for (int s = 0; s < SEND_COUNT; s++) begin
            o_stage_in[s] = v;
            if (i_ctrl.connected[s]) begin
                if (i_ctrl.routed[s]) begin
                    o_send[s]    = v;
                    o_written[s] = 1'b1;
                    v            = i_ret[s];
                end else begin
                    v = i_hist[s];
                end
            end
        end
        o_value = v;
        // A frame tick drives nothing
        if (!i_ctrl.run) begin
            o_value   = '0;
            o_written = '0;
            for (int s = 0; s < srbd_pkg::MAX_SENDS; s++) begin
                o_send[s] = '0;
            end
        end
    end

endmodule

// ===== src/send_return_routing_with_bypass_delay_unit.sv =====
`timescale 1ns / 1ps
// Top level of the send/return routing block with bypass delay.
// Depends on srbd_pkg, srbd_history_mem, srbd_send_chain and assert_macros.svh.
//
// Takes one request per clock while o_stall is low. A request is accepted, its
// SEND_COUNT history reads are issued to one ring memory per send at once, and
// when the read stage advances the stage walk runs on the read data, the stage
// inputs are written back and the result is loaded into the output register,
// which offers it until the receiver takes it. While a result waits, one more
// request is held in the read stage and the input then stalls. Each send's
// memory has one read and one write port, which allows one request per cycle
// while nothing stalls. Bypass delays of at least two frames keep a read from
// ever hitting the frame written in the same cycle.
// After reset a clearing pass zeroes all 2**(PW+FW) rows of every ring (256 at
// the defaults), one row a cycle; requests are stalled meanwhile, configuration
// writes are taken as ever.
`include "assert_macros.svh"

module send_return_routing_with_bypass_delay_unit #(
    parameter int PORT_COUNT  = 8,
    parameter int SEND_COUNT  = 8,
    parameter int DELAY_DEPTH = 32,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [srbd_pkg::CFG_BITS-1:0] i_cfg_data,
    // request channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [2:0]                    i_port,
    input  logic                          i_active,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_end_frame,
    input  logic signed [SAMPLE_BITS-1:0] i_return_0,
    input  logic signed [SAMPLE_BITS-1:0] i_return_1,
    input  logic signed [SAMPLE_BITS-1:0] i_return_2,
    input  logic signed [SAMPLE_BITS-1:0] i_return_3,
    input  logic signed [SAMPLE_BITS-1:0] i_return_4,
    input  logic signed [SAMPLE_BITS-1:0] i_return_5,
    input  logic signed [SAMPLE_BITS-1:0] i_return_6,
    input  logic signed [SAMPLE_BITS-1:0] i_return_7,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [2:0]                    o_out_port,
    output logic signed [SAMPLE_BITS-1:0] o_port_out,
    output logic [7:0]                    o_send_written,
    output logic signed [SAMPLE_BITS-1:0] o_send_0,
    output logic signed [SAMPLE_BITS-1:0] o_send_1,
    output logic signed [SAMPLE_BITS-1:0] o_send_2,
    output logic signed [SAMPLE_BITS-1:0] o_send_3,
    output logic signed [SAMPLE_BITS-1:0] o_send_4,
    output logic signed [SAMPLE_BITS-1:0] o_send_5,
    output logic signed [SAMPLE_BITS-1:0] o_send_6,
    output logic signed [SAMPLE_BITS-1:0] o_send_7
);

    localparam int NS = srbd_pkg::MAX_SENDS;
    localparam int FB = srbd_pkg::DELAY_FIELD_BITS;
    localparam int PW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam int FW = $clog2(DELAY_DEPTH);
    localparam int AW = PW + FW;
    localparam int DW = ((FW + 1) > FB) ? (FW + 1) : FB;
    localparam logic [FW-1:0] FP_LAST   = FW'(DELAY_DEPTH - 1);
    localparam logic [DW-1:0] DEPTH_W   = DW'(DELAY_DEPTH);
    localparam logic [DW-1:0] DELAY_MAX = DW'(DELAY_DEPTH - 1);
    localparam logic [4:0]    PORT_LIM  = 5'(PORT_COUNT);

    // ---------------- configuration ----------------
    logic [srbd_pkg::ROUTE_BITS-1:0]     r_route_mask;
    logic [srbd_pkg::DELAY_REG_BITS-1:0] r_bypass;
    logic [NS-1:0]                       r_ret_conn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_route_mask <= '0;
            r_bypass     <= srbd_pkg::BYPASS_RESET;
            r_ret_conn   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                srbd_pkg::CFG_ROUTE_MASK: begin
                    r_route_mask <= i_cfg_data;
                end
                srbd_pkg::CFG_BYPASS_DELAYS: begin
                    r_bypass <= i_cfg_data[srbd_pkg::DELAY_REG_BITS-1:0];
                end
                srbd_pkg::CFG_RETURN_CONNECTED: begin
                    r_ret_conn <= i_cfg_data[NS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- control state ----------------
    logic          r_clr_busy, n_clr_busy;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic [FW-1:0] r_fp, n_fp;
    logic          r_s1_valid, n_s1_valid;
    logic          r_out_valid, n_out_valid;

    logic in_accept;
    logic s1_adv;
    logic w_item_wr;

    assign s1_adv    = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_clr_busy || (r_s1_valid && !s1_adv);
    assign in_accept = i_valid && !o_stall;

    always_comb begin
        n_clr_busy  = r_clr_busy;
        n_clr_addr  = r_clr_addr;
        n_fp        = r_fp;
        n_s1_valid  = r_s1_valid;
        n_out_valid = r_out_valid;
        if (r_clr_busy) begin
            n_clr_addr = r_clr_addr + AW'(1);
            if (r_clr_addr == '1) begin
                n_clr_busy = 1'b0;
            end
        end
        if (in_accept && i_end_frame) begin
            n_fp = (r_fp == FP_LAST) ? '0 : r_fp + FW'(1);
        end
        if (in_accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
        if (s1_adv) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_fp        <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_clr_busy  <= n_clr_busy;
            r_clr_addr  <= n_clr_addr;
            r_fp        <= n_fp;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // ---------------- request decode ----------------
    logic signed [SAMPLE_BITS-1:0] w_ret_in [NS];
    assign w_ret_in[0] = i_return_0;
    assign w_ret_in[1] = i_return_1;
    assign w_ret_in[2] = i_return_2;
    assign w_ret_in[3] = i_return_3;
    assign w_ret_in[4] = i_return_4;
    assign w_ret_in[5] = i_return_5;
    assign w_ret_in[6] = i_return_6;
    assign w_ret_in[7] = i_return_7;

    logic [PW-1:0]         w_pidx;
    logic [FW-1:0]         w_rframe [NS];
    srbd_pkg::t_stage_ctrl w_ctrl;

    assign w_pidx = PW'(i_port);

    always_comb begin
        logic [DW-1:0] d;
        logic [DW-1:0] fpx;
        logic [DW-1:0] rf;
        fpx = DW'(r_fp);
        w_ctrl.run       = i_active && ({2'b00, i_port} < PORT_LIM);
        w_ctrl.connected = r_ret_conn;
        for (int s = 0; s < NS; s++) begin
            w_ctrl.routed[s] = r_route_mask[{i_port, 3'(s)}];
            // saturate the delay to 2 .. DELAY_DEPTH-1
            d = DW'(r_bypass[s*FB +: FB]);
            if (d < DW'(srbd_pkg::MIN_DELAY)) begin
                d = DW'(srbd_pkg::MIN_DELAY);
            end
            if (d > DELAY_MAX) begin
                d = DELAY_MAX;
            end
            rf = (fpx >= d) ? (fpx - d) : (fpx + DEPTH_W - d);
            w_rframe[s] = rf[FW-1:0];
        end
    end

    // ---------------- read stage ----------------
    logic [2:0]                    r_s1_port;
    logic [PW-1:0]                 r_s1_pidx;
    logic [FW-1:0]                 r_s1_fp;
    logic signed [SAMPLE_BITS-1:0] r_s1_sample;
    logic signed [SAMPLE_BITS-1:0] r_s1_ret [NS];
    srbd_pkg::t_stage_ctrl         r_s1_ctrl;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_port   <= i_port;
            r_s1_pidx   <= w_pidx;
            r_s1_fp     <= r_fp;
            r_s1_sample <= i_sample;
            r_s1_ret    <= w_ret_in;
            r_s1_ctrl   <= w_ctrl;
        end
    end

    assign w_item_wr = s1_adv && r_s1_ctrl.run;

    logic signed [SAMPLE_BITS-1:0] w_hist     [NS];
    logic signed [SAMPLE_BITS-1:0] w_stage_in [NS];
    logic signed [SAMPLE_BITS-1:0] w_send     [NS];
    logic signed [SAMPLE_BITS-1:0] w_value;
    logic [NS-1:0]                 w_written;

    for (genvar s = 0; s < NS; s++) begin : g_ring
        if (s < SEND_COUNT) begin : g_used
            logic [SAMPLE_BITS-1:0] w_rdata;
            srbd_history_mem #(
                .ADDR_BITS (AW),
                .DATA_BITS (SAMPLE_BITS)
            ) u_mem (
                .i_clk   (i_clk),
                .i_we    (r_clr_busy || w_item_wr),
                .i_waddr (r_clr_busy ? r_clr_addr : {r_s1_pidx, r_s1_fp}),
                .i_wdata (r_clr_busy ? '0 : w_stage_in[s]),
                .i_re    (in_accept),
                .i_raddr ({w_pidx, w_rframe[s]}),
                .o_rdata (w_rdata)
            );
            assign w_hist[s] = w_rdata;
        end else begin : g_unused
            assign w_hist[s] = '0;
        end
    end

    srbd_send_chain #(
        .SEND_COUNT  (SEND_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_chain (
        .i_ctrl     (r_s1_ctrl),
        .i_sample   (r_s1_sample),
        .i_ret      (r_s1_ret),
        .i_hist     (w_hist),
        .o_value    (w_value),
        .o_written  (w_written),
        .o_send     (w_send),
        .o_stage_in (w_stage_in)
    );

    // ---------------- output register ----------------
    logic [2:0]                    r_out_port;
    logic signed [SAMPLE_BITS-1:0] r_out_value;
    logic [NS-1:0]                 r_out_written;
    logic signed [SAMPLE_BITS-1:0] r_out_send [NS];

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_port    <= r_s1_port;
            r_out_value   <= w_value;
            r_out_written <= w_written;
            r_out_send    <= w_send;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_port     = r_out_port;
    assign o_port_out     = r_out_value;
    assign o_send_written = r_out_written;
    assign o_send_0       = r_out_send[0];
    assign o_send_1       = r_out_send[1];
    assign o_send_2       = r_out_send[2];
    assign o_send_3       = r_out_send[3];
    assign o_send_4       = r_out_send[4];
    assign o_send_5       = r_out_send[5];
    assign o_send_6       = r_out_send[6];
    assign o_send_7       = r_out_send[7];

    // ---------------- checks ----------------
    logic w_clash;
    always_comb begin
        w_clash = 1'b0;
        for (int s = 0; s < SEND_COUNT; s++) begin
            if ((w_pidx == r_s1_pidx) && (w_rframe[s] == r_s1_fp)) begin
                w_clash = 1'b1;
            end
        end
    end

    `SRBD_ASSERT(a_no_rw_clash, i_clk, i_rst_n, !(w_item_wr && in_accept && w_clash))
    `SRBD_ASSERT_NXT(a_fp_hold, i_clk, i_rst_n, !(in_accept && i_end_frame), $stable(r_fp))
    `SRBD_ASSERT_IMP(a_sends_connected, i_clk, i_rst_n, r_out_valid, (r_out_written & ~r_ret_conn) == '0)

endmodule

// ===== dv/tb_send_return_routing_with_bypass_delay_unit.sv =====
`timescale 1ns / 1ps
// Testbench for send_return_routing_with_bypass_delay_unit: directed and random requests,
// each checked against an in-bench routing predictor that keeps its own bypass history.
// Depends on srbd_pkg and the RTL of the routing block.
module tb_send_return_routing_with_bypass_delay_unit;

    localparam int PORTS             = 8;
    localparam int SENDS             = 8;
    localparam int DEPTH             = 32;
    localparam int SAMPLE_BITS       = 24;
    localparam int RESET_CYCLES      = 12;
    localparam int SETTLE_CYCLES     = 4;
    localparam int QUIET_LIMIT       = 4000;
    localparam int ITEMS_PER_SETTING = 100;
    localparam int RANDOM_SETTINGS   = 7;
    localparam int MAX_REPORTS       = 40;
    localparam int DRB               = srbd_pkg::DELAY_REG_BITS;
    localparam int DFB               = srbd_pkg::DELAY_FIELD_BITS;

    typedef logic [SAMPLE_BITS-1:0]            t_sample;
    typedef logic [SENDS-1:0][SAMPLE_BITS-1:0] t_send_bus;

    typedef struct packed {
        logic [2:0] port;
        logic       active;
        t_sample    sample;
        logic       end_frame;
        t_send_bus  returns;
    } t_request;

    typedef struct packed {
        logic [2:0]       port;
        t_sample          port_out;
        logic [SENDS-1:0] written;
        t_send_bus        sends;
    } t_routed;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [1:0]                    i_cfg_idx;
    logic [srbd_pkg::CFG_BITS-1:0] i_cfg_data;
    logic                          i_valid;
    logic                          o_stall;
    logic [2:0]                    i_port;
    logic                          i_active;
    t_sample                       i_sample;
    logic                          i_end_frame;
    t_sample                       i_return_0, i_return_1, i_return_2, i_return_3;
    t_sample                       i_return_4, i_return_5, i_return_6, i_return_7;
    logic                          o_valid;
    logic                          i_stall;
    logic [2:0]                    o_out_port;
    t_sample                       o_port_out;
    logic [7:0]                    o_send_written;
    t_sample                       o_send_0, o_send_1, o_send_2, o_send_3;
    t_sample                       o_send_4, o_send_5, o_send_6, o_send_7;

    // Predictor state
    t_sample                             ring_history [PORTS][SENDS][DEPTH];
    logic [4:0]                          frame_ptr;
    logic [srbd_pkg::ROUTE_BITS-1:0]     route_mask_q;
    logic [DRB-1:0]                      bypass_delays_q;
    logic [SENDS-1:0]                    return_conn_q;
    t_routed                             expected_routing [$];

    int idle_pct;
    int stall_pct;
    int requests_taken;
    int results_checked;
    int mismatches;
    int settings_applied;
    int quiet_cycles;

    always #2 i_clk = ~i_clk;

    send_return_routing_with_bypass_delay_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_port         (i_port),
        .i_active       (i_active),
        .i_sample       (i_sample),
        .i_end_frame    (i_end_frame),
        .i_return_0     (i_return_0),
        .i_return_1     (i_return_1),
        .i_return_2     (i_return_2),
        .i_return_3     (i_return_3),
        .i_return_4     (i_return_4),
        .i_return_5     (i_return_5),
        .i_return_6     (i_return_6),
        .i_return_7     (i_return_7),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_port     (o_out_port),
        .o_port_out     (o_port_out),
        .o_send_written (o_send_written),
        .o_send_0       (o_send_0),
        .o_send_1       (o_send_1),
        .o_send_2       (o_send_2),
        .o_send_3       (o_send_3),
        .o_send_4       (o_send_4),
        .o_send_5       (o_send_5),
        .o_send_6       (o_send_6),
        .o_send_7       (o_send_7)
    );

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at result %0d: %s got %0h want %0h",
                     results_checked, what, got, want);
    endtask

    // Walk the send stages for one request and advance the frame pointer on end_frame.
    task automatic route_request(input t_request r, output t_routed res);
        t_sample    value;
        logic [4:0] delay;
        logic [4:0] tap;
        res      = '0;
        res.port = r.port;
        if (r.active) begin
            value = r.sample;
            for (int s = 0; s < SENDS; s++) begin
                ring_history[r.port][s][frame_ptr] = value;
                if (return_conn_q[s]) begin
                    if (route_mask_q[r.port * 8 + s]) begin
                        res.sends[s]   = value;
                        res.written[s] = 1'b1;
                        value          = r.returns[s];
                    end else begin
                        delay = bypass_delays_q[s * DFB +: DFB];
                        if (delay < srbd_pkg::MIN_DELAY)
                            delay = srbd_pkg::MIN_DELAY;
                        // 5-bit subtraction wraps round the ring
                        tap   = frame_ptr - delay;
                        value = ring_history[r.port][s][tap];
                    end
                end
            end
            res.port_out = value;
        end
        if (r.end_frame)
            frame_ptr = frame_ptr + 5'd1;
    endtask

    // Track configuration, predict accepted requests and check accepted results.
    always @(posedge i_clk) begin
        t_request seen;
        t_routed  predicted;
        t_routed  got;
        t_routed  want;
        if (!i_rst_n) begin
            for (int p = 0; p < PORTS; p++)
                for (int s = 0; s < SENDS; s++)
                    for (int f = 0; f < DEPTH; f++)
                        ring_history[p][s][f] = '0;
            frame_ptr       = '0;
            route_mask_q    = '0;
            bypass_delays_q = srbd_pkg::BYPASS_RESET;
            return_conn_q   = '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    srbd_pkg::CFG_ROUTE_MASK:
                        route_mask_q = i_cfg_data[srbd_pkg::ROUTE_BITS-1:0];
                    srbd_pkg::CFG_BYPASS_DELAYS:
                        bypass_delays_q = i_cfg_data[DRB-1:0];
                    srbd_pkg::CFG_RETURN_CONNECTED:
                        return_conn_q = i_cfg_data[SENDS-1:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                seen.port      = i_port;
                seen.active    = i_active;
                seen.sample    = i_sample;
                seen.end_frame = i_end_frame;
                seen.returns   = {i_return_7, i_return_6, i_return_5, i_return_4,
                                  i_return_3, i_return_2, i_return_1, i_return_0};
                route_request(seen, predicted);
                expected_routing.push_back(predicted);
                requests_taken++;
            end
            if (o_valid && !i_stall) begin
                got.port     = o_out_port;
                got.port_out = o_port_out;
                got.written  = o_send_written;
                got.sends    = {o_send_7, o_send_6, o_send_5, o_send_4,
                                o_send_3, o_send_2, o_send_1, o_send_0};
                if (expected_routing.size() == 0) begin
                    report_mismatch("result with no request pending", got.port, 0);
                end else begin
                    want = expected_routing.pop_front();
                    if (got.port !== want.port)
                        report_mismatch("out_port", got.port, want.port);
                    if (got.port_out !== want.port_out)
                        report_mismatch("port_out", got.port_out, want.port_out);
                    if (got.written !== want.written)
                        report_mismatch("send_written", got.written, want.written);
                    for (int s = 0; s < SENDS; s++)
                        if (got.sends[s] !== want.sends[s])
                            report_mismatch($sformatf("send_%0d", s),
                                            got.sends[s], want.sends[s]);
                end
                results_checked++;
            end
        end
    end

    // Receiver back-pressure
    always @(posedge i_clk)
        i_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_routing.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic t_sample rand_sample();
        case ($urandom_range(7))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return 24'h000000;
            default: return t_sample'($urandom);
        endcase
    endfunction

    // Random delays mixed with the saturating values 0 and 1 and the largest value 31.
    function automatic logic [DRB-1:0] rand_delays();
        logic [DRB-1:0] d;
        for (int s = 0; s < SENDS; s++) begin
            case ($urandom_range(4))
                0:       d[s * DFB +: DFB] = 5'd0;
                1:       d[s * DFB +: DFB] = 5'd1;
                2:       d[s * DFB +: DFB] = 5'd31;
                default: d[s * DFB +: DFB] = 5'($urandom);
            endcase
        end
        return d;
    endfunction

    function automatic t_send_bus same_returns(input t_sample v);
        return {SENDS{v}};
    endfunction

    function automatic t_request make_request(input logic [2:0] port, input logic active,
                                              input t_sample sample, input logic end_frame,
                                              input t_send_bus returns);
        t_request r;
        r.port      = port;
        r.active    = active;
        r.sample    = sample;
        r.end_frame = end_frame;
        r.returns   = returns;
        return r;
    endfunction

    function automatic t_request random_request(input logic [2:0] port, input logic active,
                                                input logic end_frame);
        t_send_bus rets;
        for (int s = 0; s < SENDS; s++)
            rets[s] = rand_sample();
        return make_request(port, active, rand_sample(), end_frame, rets);
    endfunction

    task automatic set_idle_mode(input int mode);
        case (mode)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 55; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 55; end
            default: begin idle_pct = 28; stall_pct = 28; end
        endcase
    endtask

    // Offer one request and hold it until the block takes it.
    task automatic send_request(input t_request r);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_port      <= r.port;
        i_active    <= r.active;
        i_sample    <= r.sample;
        i_end_frame <= r.end_frame;
        i_return_0  <= r.returns[0];
        i_return_1  <= r.returns[1];
        i_return_2  <= r.returns[2];
        i_return_3  <= r.returns[3];
        i_return_4  <= r.returns[4];
        i_return_5  <= r.returns[5];
        i_return_6  <= r.returns[6];
        i_return_7  <= r.returns[7];
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    // Drop valid and wait until every predicted result has been checked.
    task automatic settle_block();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_routing.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_registers(input logic [63:0] route, input logic [63:0] delays,
                                   input logic [63:0] conn);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= srbd_pkg::CFG_ROUTE_MASK;
        i_cfg_data <= route;
        @(posedge i_clk);
        i_cfg_idx  <= srbd_pkg::CFG_BYPASS_DELAYS;
        i_cfg_data <= delays;
        @(posedge i_clk);
        i_cfg_idx  <= srbd_pkg::CFG_RETURN_CONNECTED;
        i_cfg_data <= conn;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        settings_applied++;
    endtask

    // Reset values: no return connected, so every sample passes straight through.
    task automatic test_reset_passthrough();
        send_request(make_request(3'd0, 1'b1, 24'h7FFFFF, 1'b0, same_returns(24'h800000)));
        send_request(make_request(3'd7, 1'b1, 24'h800000, 1'b1, same_returns(24'h7FFFFF)));
        send_request(make_request(3'd4, 1'b1, 24'h000000, 1'b0, same_returns(24'hFFFFFF)));
        settle_block();
    endtask

    // Every port routed through every send: each send carries the sample or the previous return.
    task automatic test_full_routing();
        write_registers('1, srbd_pkg::BYPASS_RESET, 64'hFF);
        send_request(make_request(3'd0, 1'b1, 24'h7FFFFF, 1'b0, same_returns(24'h800000)));
        send_request(make_request(3'd7, 1'b1, 24'h800000, 1'b1,
                                  {4{24'h7FFFFF, 24'h800000}}));
        send_request(make_request(3'd5, 1'b1, 24'h000000, 1'b0,
                                  {24'h777777, 24'h666666, 24'h555555, 24'h444444,
                                   24'h333333, 24'h222222, 24'h111111, 24'hABCDEF}));
        send_request(make_request(3'd2, 1'b1, 24'h123456, 1'b1, same_returns(24'hFFFFFF)));
    endtask

    // Frame ticks drive nothing even with full routing, yet still advance the frame.
    task automatic test_frame_tick();
        send_request(make_request(3'd0, 1'b0, 24'h7FFFFF, 1'b0, same_returns(24'h7FFFFF)));
        send_request(make_request(3'd7, 1'b0, 24'h800000, 1'b1, same_returns(24'h800000)));
        send_request(make_request(3'd3, 1'b0, 24'hFFFFFF, 1'b1, same_returns(24'h000000)));
        settle_block();
    endtask

    // Bypass at the short and long delay limits, then a mixed per-port routing.
    task automatic test_bypass_delay_limits();
        write_registers('0, '0, 64'hFF);
        for (int k = 1; k <= 5; k++)
            send_request(make_request(3'd2, 1'b1, t_sample'(k * 24'h111111), 1'b1,
                                      same_returns(24'h800000)));
        settle_block();
        write_registers('0, {DRB{1'b1}}, 64'hFF);
        for (int k = 1; k <= 3; k++)
            send_request(make_request(3'd2, 1'b1, t_sample'(24'hFFFFFF - k), 1'b1,
                                      same_returns(24'h7FFFFF)));
        settle_block();
        write_registers(64'hAAAA_AAAA_5555_5555,
                        {5'd1, 5'd30, 5'd3, 5'd17, 5'd0, 5'd2, 5'd31, 5'd1}, 64'hA5);
        send_request(make_request(3'd0, 1'b1, 24'h7FFFFF, 1'b0, same_returns(24'h0F0F0F)));
        send_request(make_request(3'd1, 1'b1, 24'h800000, 1'b1, same_returns(24'hF0F0F0)));
        send_request(make_request(3'd6, 1'b1, 24'h5A5A5A, 1'b0, same_returns(24'h7FFFFF)));
        send_request(make_request(3'd7, 1'b1, 24'hA5A5A5, 1'b1, same_returns(24'h800000)));
        settle_block();
    endtask

    // Random settings; most traffic is frames of a few ports closed by end_frame.
    task automatic test_random_routing();
        int sent;
        int frame_len;
        for (int k = 0; k < RANDOM_SETTINGS; k++) begin
            case (k)
                1:       write_registers('1, rand_delays(), 64'hFF);
                2:       write_registers('0, {DRB{1'b1}}, 64'hFF);
                3:       write_registers('0, '0, {$urandom, $urandom} | 64'hFF);
                4:       write_registers({$urandom, $urandom}, rand_delays(), 64'h00);
                6:       write_registers({$urandom, $urandom}, rand_delays(), 64'hFF);
                default: write_registers({$urandom, $urandom},
                                         {$urandom, $urandom}, {$urandom, $urandom});
            endcase
            sent = 0;
            while (sent < ITEMS_PER_SETTING) begin
                set_idle_mode((sent / 25) % 4);
                if ($urandom_range(99) < 85) begin
                    frame_len = ($urandom_range(3) == 0) ? $urandom_range(1, 8)
                                                         : $urandom_range(1, 2);
                    for (int i = 0; i < frame_len; i++)
                        send_request(random_request(3'($urandom), $urandom_range(15) != 0,
                                                    i == frame_len - 1));
                    sent += frame_len;
                end else begin
                    send_request(random_request(3'($urandom), 1'($urandom), 1'($urandom)));
                    sent++;
                end
            end
            set_idle_mode(0);
            settle_block();
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= srbd_pkg::CFG_ROUTE_MASK;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_port      <= '0;
        i_active    <= 1'b0;
        i_sample    <= '0;
        i_end_frame <= 1'b0;
        i_return_0  <= '0;
        i_return_1  <= '0;
        i_return_2  <= '0;
        i_return_3  <= '0;
        i_return_4  <= '0;
        i_return_5  <= '0;
        i_return_6  <= '0;
        i_return_7  <= '0;
        i_stall     <= 1'b0;
        idle_pct         = 0;
        stall_pct        = 0;
        requests_taken   = 0;
        results_checked  = 0;
        mismatches       = 0;
        settings_applied = 0;
        quiet_cycles     = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_passthrough();
        test_full_routing();
        test_frame_tick();
        test_bypass_delay_limits();
        test_random_routing();
        settle_block();

        $display("Run covered %0d requests and %0d checked results over %0d register settings",
                 requests_taken, results_checked, settings_applied);
        $display("with free-running, sender-idle, receiver-stall and mixed traffic; %0d mismatches",
                 mismatches + expected_routing.size());
        if (mismatches == 0 && expected_routing.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/srbd_pkg.sv
src/srbd_history_mem.sv
src/srbd_send_chain.sv
src/send_return_routing_with_bypass_delay_unit.sv
dv/tb_send_return_routing_with_bypass_delay_unit.sv
